@@ rtl/pgcr_pkg.sv @@
package pgcr_pkg;
  localparam int FontBytesDef = 4096;
  localparam int MaxWidthDef  = 64;
  localparam int MaxHeightDef = 32;
  localparam int QDepth       = 2;

  localparam logic [1:0] ModeWrite  = 2'd0;
  localparam logic [1:0] ModeDraw   = 2'd1;
  localparam logic [1:0] ModeCursor = 2'd2;
  localparam logic [1:0] ModeNone   = 2'd3;

  localparam logic [2:0] RegFixed   = 3'd0;
  localparam logic [2:0] RegXScale  = 3'd1;
  localparam logic [2:0] RegYScale  = 3'd2;
  localparam logic [2:0] RegSpacing = 3'd3;
  localparam logic [2:0] RegMaxX    = 3'd4;

  typedef struct packed {
    logic [1:0]  mode;
    logic [11:0] font_addr;
    logic [7:0]  font_byte;
    logic [7:0]  char_code;
    logic [15:0] new_cursor_x;
    logic [15:0] new_cursor_y;
  } item_t;

  function automatic logic is_thai(input logic [7:0] c);
    is_thai = (c >= 8'hd4 && c <= 8'hda) || (c >= 8'he7 && c <= 8'hec) || c == 8'hd1;
  endfunction
endpackage

@@ rtl/pgcr_front.sv @@
module pgcr_front
  import pgcr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  item_t       in_item,
  output logic        q_valid,
  input  logic        q_ready,
  output item_t       q_item
);
  item_t  buf_q [QDepth];
  logic   wr_ptr, rd_ptr;
  logic [1:0] count;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_item   = buf_q[rd_ptr];

  // mode 3 transactions are dropped here and never reach the back end
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (in_valid && in_ready && in_item.mode != ModeNone) begin
        buf_q[wr_ptr] <= in_item;
        wr_ptr <= ~wr_ptr;
      end
      if (q_valid && q_ready) rd_ptr <= ~rd_ptr;
      count <= count + 2'(in_valid && in_ready && in_item.mode != ModeNone)
                     - 2'(q_valid && q_ready);
    end
  end
endmodule

@@ rtl/pgcr_back.sv @@
module pgcr_back
  import pgcr_pkg::*;
#(
  parameter int FONT_BYTES = FontBytesDef,
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  item_t       q_item,
  input  logic        fixed_width,
  input  logic [3:0]  x_scale,
  input  logic [3:0]  y_scale,
  input  logic [7:0]  char_spacing,
  input  logic [15:0] screen_max_x,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] column_x,
  output logic [15:0] column_y,
  output logic [31:0] row_bits,
  output logic [5:0]  row_count,
  output logic [15:0] advance,
  output logic        last_column
);
  localparam int AW = $clog2(FONT_BYTES);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int RIW = $clog2(MAX_HEIGHT);

  typedef enum logic [4:0] {
    S_IDLE, S_H0, S_H1, S_H2, S_H3, S_H5, S_H6, S_W, S_WD, S_CHK, S_SUM,
    S_BASE, S_GLYPH, S_RD, S_BIT, S_EMIT, S_DONE
  } state_t;

  logic [7:0]  mem [FONT_BYTES];
  logic [7:0]  rdata;
  logic [AW-1:0] raddr;
  logic        mem_we;
  logic [AW-1:0] waddr;
  logic [7:0]  wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  state_t state;
  logic [15:0] cur_x, cur_y;
  logic [7:0]  c, sz_lo, maxw, height, first, last, width, kidx;
  logic [15:0] sum;
  logic [31:0] pos, colbase;
  logic [CW-1:0] col, cols;
  logic [RW-1:0] r, rows;
  logic [31:0] bits;
  logic        sz_nz;
  logic [15:0] adv;

  logic [11:0] wxs;
  logic [11:0] hys;
  logic [16:0] wrap_sum;
  logic [CW-1:0] width_c;
  logic [RW-1:0] height_r;

  assign wxs = 12'(width) * 12'(x_scale);
  assign hys = 12'(height) * 12'(y_scale);
  assign wrap_sum = 17'(cur_x) + 17'(wxs);
  assign width_c = (width > 8'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(width);
  assign height_r = (height > 8'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(height);

  assign q_ready = (state == S_IDLE);
  assign mem_we = (state == S_IDLE) && q_valid && q_item.mode == ModeWrite;
  assign waddr = AW'(q_item.font_addr);
  assign wdata = q_item.font_byte;

  always_comb begin
    unique case (state)
      S_IDLE:  raddr = AW'(0);
      S_H0:    raddr = AW'(1);
      S_H1:    raddr = AW'(2);
      S_H2:    raddr = AW'(3);
      S_H3:    raddr = AW'(5);
      S_H5:    raddr = AW'(6);
      S_W:     raddr = AW'(7 + 32'(c) - 32'(first));
      S_WD:    raddr = AW'(7 + 32'h30 - 32'(first));
      S_SUM:   raddr = AW'(7 + 32'(kidx));
      S_RD:    raddr = AW'(pos >> 3);
      default: raddr = AW'(0);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_x <= '0;
      cur_y <= '0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (q_valid) begin
          unique case (q_item.mode)
            ModeCursor: begin
              cur_x <= q_item.new_cursor_x;
              cur_y <= q_item.new_cursor_y;
            end
            ModeDraw: begin
              c <= q_item.char_code;
              state <= S_H0;
            end
            default: ;
          endcase
        end
        S_H0: begin sz_lo <= rdata; state <= S_H1; end
        S_H1: begin sz_nz <= (sz_lo != 0) || (rdata != 0); state <= S_H2; end
        S_H2: begin maxw <= rdata; state <= S_H3; end
        S_H3: begin height <= rdata; state <= S_H5; end
        S_H5: begin
          first <= rdata;
          if (c == 8'h0a) begin
            cur_y <= cur_y + 16'(hys);
            cur_x <= '0;
          end
          state <= S_H6;
        end
        S_H6: begin last <= rdata; state <= S_W; end
        S_W: begin
          if (c < first || c > last || !sz_nz) state <= S_IDLE;
          else state <= S_WD;
        end
        S_WD: begin
          // own width read back now; digit width arrives next cycle
          if (rdata == 0) state <= S_IDLE;
          else begin
            width <= fixed_width ? maxw : rdata;
            if (!fixed_width && is_thai(c))
              cur_x <= cur_x - 16'(12'(rdata) * 12'(x_scale));
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (c >= 8'h30 && c <= 8'h39 && first <= 8'h30) width <= rdata;
          kidx <= '0;
          sum <= '0;
          state <= S_SUM;
        end
        S_SUM: begin
          // one width entry per cycle; read data arrives in the cycle after its address
          if (kidx != 0) sum <= sum + 16'(rdata);
          if (kidx == c - first) state <= S_BASE;
          else kidx <= kidx + 8'd1;
          if (kidx == 0 && wrap_sum > 17'(screen_max_x)) begin
            cur_y <= cur_y + 16'(hys);
            cur_x <= '0;
          end
        end
        S_BASE: begin
          colbase <= (32'(last) - 32'(first) + 32'd8) * 32'd8
                     + 32'(sum) * 32'(height);
          adv <= 16'(wxs) + 16'(char_spacing);
          cols <= width_c;
          rows <= height_r;
          col <= '0;
          state <= S_GLYPH;
        end
        S_GLYPH: begin
          if (col == cols) begin
            cur_x <= cur_x + adv;
            state <= S_IDLE;
          end else begin
            r <= '0;
            bits <= '0;
            pos <= colbase;
            state <= (rows == 0) ? S_EMIT : S_RD;
          end
        end
        S_RD: state <= S_BIT;
        S_BIT: begin
          bits[r[RIW-1:0]] <= rdata[pos[2:0]];
          pos <= pos + 32'd1;
          r <= r + RW'(1);
          state <= (r + RW'(1) == rows) ? S_EMIT : S_RD;
        end
        S_EMIT: if (!out_valid || out_ready) begin
          out_valid <= 1'b1;
          column_x <= 16'(32'(col) * 32'(x_scale)) + cur_x;
          column_y <= cur_y;
          row_bits <= bits;
          row_count <= 6'(rows);
          advance <= adv;
          last_column <= (col + CW'(1) == cols);
          col <= col + CW'(1);
          colbase <= colbase + 32'(height);
          state <= S_GLYPH;
        end
        default: state <= S_IDLE;
      endcase
      if (out_valid && out_ready && !(state == S_EMIT)) out_valid <= 1'b0;
    end
  end
endmodule

@@ rtl/proportional_glyph_column_renderer_top.sv @@
// The back end takes one transaction at a time; its pace is bounded by the width sum
// (one table byte a cycle) and the bit fetch (one font byte read per row bit).
// Font writes and cursor loads are handled in the back end's idle state without leaving it.
// Reset (rst, synchronous): cursor to zero, registers to defaults, queue empty.
// Font memory is not cleared.
module proportional_glyph_column_renderer_top
  import pgcr_pkg::*;
#(
  parameter int FONT_BYTES = FontBytesDef,
  parameter int MAX_WIDTH  = MaxWidthDef,
  parameter int MAX_HEIGHT = MaxHeightDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [11:0] font_addr,
  input  logic [7:0]  font_byte,
  input  logic [7:0]  char_code,
  input  logic [15:0] new_cursor_x,
  input  logic [15:0] new_cursor_y,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] column_x,
  output logic [15:0] column_y,
  output logic [31:0] row_bits,
  output logic [5:0]  row_count,
  output logic [15:0] advance,
  output logic        last_column
);
  logic fixed_width;
  logic [3:0] x_scale, y_scale;
  logic [7:0] char_spacing;
  logic [15:0] screen_max_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      fixed_width <= 1'b0;
      x_scale <= 4'd1;
      y_scale <= 4'd1;
      char_spacing <= 8'd1;
      screen_max_x <= 16'd319;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegFixed:   fixed_width <= cfg_data[0];
        RegXScale:  x_scale <= cfg_data[3:0];
        RegYScale:  y_scale <= cfg_data[3:0];
        RegSpacing: char_spacing <= cfg_data[7:0];
        RegMaxX:    screen_max_x <= cfg_data;
        default: ;
      endcase
    end
  end

  item_t in_item, q_item;
  logic q_valid, q_ready;

  assign in_item = '{mode: mode, font_addr: font_addr, font_byte: font_byte,
                     char_code: char_code, new_cursor_x: new_cursor_x,
                     new_cursor_y: new_cursor_y};

  pgcr_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_item,
    .q_valid, .q_ready, .q_item
  );

  pgcr_back #(.FONT_BYTES(FONT_BYTES), .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT))
  u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item,
    .fixed_width, .x_scale, .y_scale, .char_spacing, .screen_max_x,
    .out_valid, .out_ready, .column_x, .column_y, .row_bits, .row_count,
    .advance, .last_column
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(row_bits) && $stable(column_x))
    else $error("result changed while stalled");
  a_rows: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> row_count <= 6'(MAX_HEIGHT))
    else $error("row count beyond limit");
  a_q_order: assert property (@(posedge clk) disable iff (rst)
    q_valid && !q_ready |=> q_valid)
    else $error("queue lost an entry");
endmodule
